// ===== hw/rtl/der_rsa_private_key_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the DER RSA private key parser RTL.
// ---------------------------------------------------------------------------
`ifndef DER_RSA_PRIVATE_KEY_PARSER_DEFINES_SVH
`define DER_RSA_PRIVATE_KEY_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRPK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRPK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/drpk_pkg.sv =====
// ---------------------------------------------------------------------------
// drpk_pkg
// Types and constants for the DER RSA private key parser.
// ---------------------------------------------------------------------------
`default_nettype none

package drpk_pkg;

    // Longest long-form length accepted, in bytes
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_CNT_W        = $clog2(MAX_LENGTH_BYTES + 1);

    // DER tags
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;

    // Index of the last integer (qi)
    localparam logic [2:0] LAST_ELEMENT = 3'd7;

    // Status codes
    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Parser phases
    localparam logic [4:0] PH_OUTER_TAG  = 5'd0;
    localparam logic [4:0] PH_OUTER_LEN  = 5'd1;
    localparam logic [4:0] PH_VER_TAG    = 5'd2;
    localparam logic [4:0] PH_VER_LEN    = 5'd3;
    localparam logic [4:0] PH_VER_SKIP   = 5'd4;
    localparam logic [4:0] PH_SELECT     = 5'd5;
    localparam logic [4:0] PH_ALG_LEN    = 5'd6;
    localparam logic [4:0] PH_ALG_SKIP   = 5'd7;
    localparam logic [4:0] PH_OCT_TAG    = 5'd8;
    localparam logic [4:0] PH_OCT_LEN    = 5'd9;
    localparam logic [4:0] PH_INSEQ_TAG  = 5'd10;
    localparam logic [4:0] PH_INSEQ_LEN  = 5'd11;
    localparam logic [4:0] PH_INVER_TAG  = 5'd12;
    localparam logic [4:0] PH_INVER_LEN  = 5'd13;
    localparam logic [4:0] PH_INVER_SKIP = 5'd14;
    localparam logic [4:0] PH_INT_TAG    = 5'd15;
    localparam logic [4:0] PH_INT_LEN    = 5'd16;
    localparam logic [4:0] PH_INT_DATA   = 5'd17;
    localparam logic [4:0] PH_DONE       = 5'd18;
    localparam logic [4:0] PH_ERROR      = 5'd19;

    // Input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } key_item_t;

    // Result word
    typedef struct packed {
        logic       data_valid;
        logic [2:0] element;
        logic [7:0] data_byte;
        logic       element_end;
        logic [1:0] status;
    } res_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/drpk_step.sv =====
// ---------------------------------------------------------------------------
// drpk_step
// Parser state and one-byte step logic: tag checks, length decode, skips,
// integer content stripping and status.
// ---------------------------------------------------------------------------
`default_nettype none
`include "der_rsa_private_key_parser_defines.svh"

module drpk_step (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire drpk_pkg::key_item_t item,
    output drpk_pkg::res_item_t      result
);

    logic [4:0]                     phase_reg, phase_next;
    logic [31:0]                    content_left_reg, content_left_next;
    logic [drpk_pkg::LEN_CNT_W-1:0] len_left_reg, len_left_next;
    logic [2:0]                     elem_reg, elem_next;
    logic                           lead_zero_reg, lead_zero_next;

    logic [7:0]                     b;
    logic                           dv;
    logic                           ee;
    logic [1:0]                     st;

    // length byte decode
    logic [31:0]                    cl_len;
    logic [drpk_pkg::LEN_CNT_W-1:0] ll_len;
    logic                           len_done;
    logic                           len_err;
    logic [31:0]                    cl_dec;

    assign b      = item.in_byte;
    assign cl_dec = content_left_reg - 32'd1;

    // short form, long form header, or one more long form byte
    always_comb
    begin
        cl_len   = content_left_reg;
        ll_len   = len_left_reg;
        len_done = 1'b0;
        len_err  = 1'b0;
        if (len_left_reg == '0)
        begin
            if (!b[7])
            begin
                cl_len   = {24'd0, b};
                len_done = 1'b1;
            end
            else if (b[6:0] > 7'(drpk_pkg::MAX_LENGTH_BYTES))
            begin
                len_err = 1'b1;
            end
            else
            begin
                cl_len = '0;
                if (b[6:0] == 7'd0)
                    len_done = 1'b1;
                else
                    ll_len = b[drpk_pkg::LEN_CNT_W-1:0];
            end
        end
        else
        begin
            cl_len   = {content_left_reg[23:0], b};
            ll_len   = len_left_reg - drpk_pkg::LEN_CNT_W'(1);
            len_done = (len_left_reg == drpk_pkg::LEN_CNT_W'(1));
        end
    end

    // phase transitions
    always_comb
    begin
        phase_next        = phase_reg;
        content_left_next = content_left_reg;
        len_left_next     = len_left_reg;
        elem_next         = elem_reg;
        lead_zero_next    = lead_zero_reg;
        dv                = 1'b0;
        ee                = 1'b0;

        unique case (phase_reg)
            drpk_pkg::PH_OUTER_TAG:
                phase_next = (b == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_OUTER_LEN
                                                           : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_VER_TAG:
                phase_next = (b == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_VER_LEN
                                                          : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_OCT_TAG:
                phase_next = (b == drpk_pkg::TAG_OCTETS) ? drpk_pkg::PH_OCT_LEN
                                                         : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_INSEQ_TAG:
                phase_next = (b == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_INSEQ_LEN
                                                           : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_INVER_TAG:
                phase_next = (b == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_INVER_LEN
                                                          : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_SELECT:
            begin
                // PKCS#8 wrapper or straight into the modulus
                if (b == drpk_pkg::TAG_SEQUENCE)
                    phase_next = drpk_pkg::PH_ALG_LEN;
                else if (b == drpk_pkg::TAG_INTEGER)
                begin
                    lead_zero_next = 1'b1;
                    phase_next     = drpk_pkg::PH_INT_LEN;
                end
                else
                    phase_next = drpk_pkg::PH_ERROR;
            end
            drpk_pkg::PH_INT_TAG:
            begin
                if (b == drpk_pkg::TAG_INTEGER)
                begin
                    lead_zero_next = 1'b1;
                    phase_next     = drpk_pkg::PH_INT_LEN;
                end
                else
                    phase_next = drpk_pkg::PH_ERROR;
            end
            drpk_pkg::PH_OUTER_LEN, drpk_pkg::PH_VER_LEN, drpk_pkg::PH_ALG_LEN,
            drpk_pkg::PH_OCT_LEN, drpk_pkg::PH_INSEQ_LEN, drpk_pkg::PH_INVER_LEN,
            drpk_pkg::PH_INT_LEN:
            begin
                if (len_err)
                    phase_next = drpk_pkg::PH_ERROR;
                else
                begin
                    content_left_next = cl_len;
                    len_left_next     = ll_len;
                    if (len_done)
                    begin
                        priority case (phase_reg)
                            drpk_pkg::PH_OUTER_LEN:
                                phase_next = drpk_pkg::PH_VER_TAG;
                            drpk_pkg::PH_VER_LEN:
                                phase_next = (cl_len != '0) ? drpk_pkg::PH_VER_SKIP
                                                            : drpk_pkg::PH_SELECT;
                            drpk_pkg::PH_ALG_LEN:
                                phase_next = (cl_len != '0) ? drpk_pkg::PH_ALG_SKIP
                                                            : drpk_pkg::PH_OCT_TAG;
                            drpk_pkg::PH_OCT_LEN:
                                phase_next = drpk_pkg::PH_INSEQ_TAG;
                            drpk_pkg::PH_INSEQ_LEN:
                                phase_next = drpk_pkg::PH_INVER_TAG;
                            drpk_pkg::PH_INVER_LEN:
                                phase_next = (cl_len != '0) ? drpk_pkg::PH_INVER_SKIP
                                                            : drpk_pkg::PH_INT_TAG;
                            default:
                            begin
                                // integer length; empty integer ends right here
                                if (cl_len != '0)
                                    phase_next = drpk_pkg::PH_INT_DATA;
                                else
                                begin
                                    ee = 1'b1;
                                    if (elem_reg == drpk_pkg::LAST_ELEMENT)
                                        phase_next = drpk_pkg::PH_DONE;
                                    else
                                    begin
                                        elem_next  = elem_reg + 3'd1;
                                        phase_next = drpk_pkg::PH_INT_TAG;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            drpk_pkg::PH_VER_SKIP, drpk_pkg::PH_ALG_SKIP, drpk_pkg::PH_INVER_SKIP:
            begin
                content_left_next = cl_dec;
                if (cl_dec == '0)
                begin
                    if (phase_reg == drpk_pkg::PH_VER_SKIP)
                        phase_next = drpk_pkg::PH_SELECT;
                    else if (phase_reg == drpk_pkg::PH_ALG_SKIP)
                        phase_next = drpk_pkg::PH_OCT_TAG;
                    else
                        phase_next = drpk_pkg::PH_INT_TAG;
                end
            end
            drpk_pkg::PH_INT_DATA:
            begin
                // strip every leading zero byte
                if (!(lead_zero_reg && b == 8'h00))
                begin
                    lead_zero_next = 1'b0;
                    dv             = 1'b1;
                end
                content_left_next = cl_dec;
                if (cl_dec == '0)
                begin
                    ee = 1'b1;
                    if (elem_reg == drpk_pkg::LAST_ELEMENT)
                        phase_next = drpk_pkg::PH_DONE;
                    else
                    begin
                        elem_next  = elem_reg + 3'd1;
                        phase_next = drpk_pkg::PH_INT_TAG;
                    end
                end
            end
            drpk_pkg::PH_DONE:
                phase_next = drpk_pkg::PH_DONE;
            default:
                phase_next = drpk_pkg::PH_ERROR;
        endcase
    end

    // error and done phases are sticky, so status follows the next phase; a last byte before done reports error
    always_comb
    begin
        if (phase_next == drpk_pkg::PH_ERROR)
            st = drpk_pkg::ST_ERROR;
        else if (phase_next == drpk_pkg::PH_DONE)
            st = drpk_pkg::ST_DONE;
        else if (item.last_byte)
            st = drpk_pkg::ST_ERROR;
        else
            st = drpk_pkg::ST_PARSING;
    end

    // result word for this byte
    always_comb
    begin
        result.data_valid  = dv;
        result.element     = (dv || ee) ? elem_reg : 3'd0;
        result.data_byte   = dv ? b : 8'h00;
        result.element_end = ee;
        result.status      = st;
    end

    // state update; the last byte of a key restarts the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= drpk_pkg::PH_OUTER_TAG;
            content_left_reg <= '0;
            len_left_reg     <= '0;
            elem_reg         <= '0;
            lead_zero_reg    <= 1'b1;
        end
        else if (step_en)
        begin
            if (item.last_byte)
            begin
                phase_reg        <= drpk_pkg::PH_OUTER_TAG;
                content_left_reg <= '0;
                len_left_reg     <= '0;
                elem_reg         <= '0;
                lead_zero_reg    <= 1'b1;
            end
            else
            begin
                phase_reg        <= phase_next;
                content_left_reg <= content_left_next;
                len_left_reg     <= len_left_next;
                elem_reg         <= elem_next;
                lead_zero_reg    <= lead_zero_next;
            end
        end
    end

    `DRPK_ASSERT_NOW(a_done_on_last_elem, clk, rst_n,
        phase_reg == drpk_pkg::PH_DONE, elem_reg == drpk_pkg::LAST_ELEMENT,
        "done phase reached before the last integer")
    `DRPK_ASSERT_NOW(a_len_count_in_len_phase, clk, rst_n,
        len_left_reg != '0,
        phase_reg == drpk_pkg::PH_OUTER_LEN || phase_reg == drpk_pkg::PH_VER_LEN ||
        phase_reg == drpk_pkg::PH_ALG_LEN || phase_reg == drpk_pkg::PH_OCT_LEN ||
        phase_reg == drpk_pkg::PH_INSEQ_LEN || phase_reg == drpk_pkg::PH_INVER_LEN ||
        phase_reg == drpk_pkg::PH_INT_LEN || phase_reg == drpk_pkg::PH_ERROR,
        "long length bytes pending outside a length phase")
    `DRPK_ASSERT_NOW(a_last_restarts, clk, rst_n,
        step_en && item.last_byte, 1'b1 ##1 phase_reg == drpk_pkg::PH_OUTER_TAG,
        "parser did not restart after the last byte")

endmodule

`default_nettype wire

// ===== hw/rtl/der_rsa_private_key_parser.sv =====
// An accepted byte is held in the input register, then stepped into the result register, which drives the output.
// Throughput: one byte per cycle while the result register is free; the parser state update is a registered loop.
// A stalled result stays in the output register while the input register takes one more byte.
// Reset (rst_n low, async) empties both registers and puts the parser at the outer tag.
// ---------------------------------------------------------------------------
// der_rsa_private_key_parser
// Streaming DER RSA private key parser (PKCS#1 or PKCS#8 wrapped): emits the
// content bytes of the eight key integers with leading zeros stripped.
// ---------------------------------------------------------------------------
`default_nettype none
`include "der_rsa_private_key_parser_defines.svh"

module der_rsa_private_key_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                key_valid,
    output logic                     key_ready,
    input  wire drpk_pkg::key_item_t key_data,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output drpk_pkg::res_item_t      res_data
);

    logic                s1_valid_reg;
    drpk_pkg::key_item_t s1_item_reg;
    logic                out_valid_reg;
    drpk_pkg::res_item_t out_item_reg;

    logic                out_free;
    logic                advance;
    drpk_pkg::res_item_t step_res;

    // pipeline flow control
    assign out_free  = !out_valid_reg || res_ready;
    assign advance   = s1_valid_reg && out_free;
    assign key_ready = !s1_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (key_ready)
            s1_valid_reg <= key_valid;
    end

    always_ff @(posedge clk)
    begin
        if (key_ready && key_valid)
            s1_item_reg <= key_data;
    end

    // parser step
    drpk_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (s1_item_reg),
        .result  (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= step_res;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_item_reg;

    `DRPK_ASSERT_NOW(a_byte_needs_valid, clk, rst_n,
        out_valid_reg && out_item_reg.data_byte != 8'h00, out_item_reg.data_valid,
        "nonzero data byte without data_valid")
    `DRPK_ASSERT_NOW(a_element_needs_flag, clk, rst_n,
        out_valid_reg && out_item_reg.element != 3'd0,
        out_item_reg.data_valid || out_item_reg.element_end,
        "element index shown without data or end flag")
    `DRPK_ASSERT_NEXT(a_advance_fills_out, clk, rst_n,
        advance, out_valid_reg,
        "stepped byte did not reach the result register")

endmodule

`default_nettype wire

// ===== tb/der_rsa_private_key_parser_tb.sv =====
// ---------------------------------------------------------------------------
// der_rsa_private_key_parser_tb
// Self-checking bench for the streaming DER key parser. Key bytes go in one
// word per handshake; a local model of the parser predicts every result word
// and a checker compares them in order. Keys are built from random content:
// PKCS#1 and PKCS#8 framings, short and long lengths, damaged and cut-short
// keys and plain noise, under several idle patterns on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module der_rsa_private_key_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] LONG_FORM  = 8'h80;
    localparam int         TIMEOUT_NS = 4_000_000;
    localparam int         STALL_CYCLES = 300;
    localparam int         MAX_REPORTS  = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                key_valid = 1'b0;
    logic                key_ready;
    drpk_pkg::key_item_t key_data  = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    drpk_pkg::res_item_t res_data;

    // Parser model state
    logic [4:0]  ph;
    logic [31:0] run_len;
    logic [2:0]  len_bytes;
    logic [2:0]  elem_no;
    logic        in_zeros;
    logic [1:0]  key_status;

    drpk_pkg::res_item_t parsed_due[$];
    logic [7:0]          key_bytes[$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_req  = 0;
    int hold_left    = 0;
    int bad_len_pct  = 0;
    int fail_count   = 0;
    int words_checked = 0;
    int bytes_sent   = 0;
    int keys_sent    = 0;
    int keys_wrapped = 0;
    int keys_damaged = 0;
    int keys_noise   = 0;

    der_rsa_private_key_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_data  (key_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Parser model
    // -----------------------------------------------------------------------
    function automatic void restart_parser();
        ph         = drpk_pkg::PH_OUTER_TAG;
        run_len    = '0;
        len_bytes  = '0;
        elem_no    = '0;
        in_zeros   = 1'b1;
        key_status = drpk_pkg::ST_PARSING;
    endfunction

    function automatic drpk_pkg::res_item_t parse_key_byte(input drpk_pkg::key_item_t it);
        drpk_pkg::res_item_t r;
        logic [7:0]          b;
        logic [2:0]          el;
        logic [6:0]          cnt;
        bit                  len_done;
        bit                  len_err;
        bit                  ended;
        bit                  dv;

        r        = '0;
        b        = it.in_byte;
        el       = elem_no;
        len_done = 1'b0;
        len_err  = 1'b0;
        ended    = 1'b0;
        dv       = 1'b0;

        case (ph)
            drpk_pkg::PH_OUTER_TAG:
                ph = (b == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_OUTER_LEN
                                                   : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_VER_TAG:
                ph = (b == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_VER_LEN
                                                  : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_OCT_TAG:
                ph = (b == drpk_pkg::TAG_OCTETS) ? drpk_pkg::PH_OCT_LEN
                                                 : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_INSEQ_TAG:
                ph = (b == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_INSEQ_LEN
                                                   : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_INVER_TAG:
                ph = (b == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_INVER_LEN
                                                  : drpk_pkg::PH_ERROR;
            drpk_pkg::PH_SELECT:
            begin
                // a SEQUENCE here means the PKCS#8 wrapper, an INTEGER is n
                if (b == drpk_pkg::TAG_SEQUENCE)
                    ph = drpk_pkg::PH_ALG_LEN;
                else if (b == drpk_pkg::TAG_INTEGER)
                begin
                    in_zeros = 1'b1;
                    ph       = drpk_pkg::PH_INT_LEN;
                end
                else
                    ph = drpk_pkg::PH_ERROR;
            end
            drpk_pkg::PH_INT_TAG:
            begin
                if (b == drpk_pkg::TAG_INTEGER)
                begin
                    in_zeros = 1'b1;
                    ph       = drpk_pkg::PH_INT_LEN;
                end
                else
                    ph = drpk_pkg::PH_ERROR;
            end
            drpk_pkg::PH_OUTER_LEN, drpk_pkg::PH_VER_LEN, drpk_pkg::PH_ALG_LEN,
            drpk_pkg::PH_OCT_LEN, drpk_pkg::PH_INSEQ_LEN, drpk_pkg::PH_INVER_LEN,
            drpk_pkg::PH_INT_LEN:
            begin
                // short form, or long form count then big-endian bytes
                if (len_bytes == 0)
                begin
                    if (!b[7])
                    begin
                        run_len  = {24'd0, b};
                        len_done = 1'b1;
                    end
                    else
                    begin
                        cnt = b[6:0];
                        if (cnt > drpk_pkg::MAX_LENGTH_BYTES)
                            len_err = 1'b1;
                        else
                        begin
                            run_len = '0;
                            if (cnt == 0)
                                len_done = 1'b1;
                            else
                                len_bytes = cnt[2:0];
                        end
                    end
                end
                else
                begin
                    run_len   = {run_len[23:0], b};
                    len_bytes = len_bytes - 3'd1;
                    len_done  = (len_bytes == 0);
                end

                if (len_err)
                    ph = drpk_pkg::PH_ERROR;
                else if (len_done)
                begin
                    case (ph)
                        drpk_pkg::PH_OUTER_LEN:
                            ph = drpk_pkg::PH_VER_TAG;
                        drpk_pkg::PH_VER_LEN:
                            ph = (run_len != 0) ? drpk_pkg::PH_VER_SKIP
                                                : drpk_pkg::PH_SELECT;
                        drpk_pkg::PH_ALG_LEN:
                            ph = (run_len != 0) ? drpk_pkg::PH_ALG_SKIP
                                                : drpk_pkg::PH_OCT_TAG;
                        drpk_pkg::PH_OCT_LEN:
                            ph = drpk_pkg::PH_INSEQ_TAG;
                        drpk_pkg::PH_INSEQ_LEN:
                            ph = drpk_pkg::PH_INVER_TAG;
                        drpk_pkg::PH_INVER_LEN:
                            ph = (run_len != 0) ? drpk_pkg::PH_INVER_SKIP
                                                : drpk_pkg::PH_INT_TAG;
                        default:
                        begin
                            if (run_len != 0)
                                ph = drpk_pkg::PH_INT_DATA;
                            else
                                ended = 1'b1;
                        end
                    endcase
                end
            end
            drpk_pkg::PH_VER_SKIP, drpk_pkg::PH_ALG_SKIP, drpk_pkg::PH_INVER_SKIP:
            begin
                run_len = run_len - 32'd1;
                if (run_len == 0)
                    ph = (ph == drpk_pkg::PH_VER_SKIP) ? drpk_pkg::PH_SELECT :
                         (ph == drpk_pkg::PH_ALG_SKIP) ? drpk_pkg::PH_OCT_TAG :
                                                         drpk_pkg::PH_INT_TAG;
            end
            drpk_pkg::PH_INT_DATA:
            begin
                // drop zero bytes until the first nonzero one
                if (!(in_zeros && b == 8'h00))
                begin
                    in_zeros = 1'b0;
                    dv       = 1'b1;
                end
                run_len = run_len - 32'd1;
                if (run_len == 0)
                    ended = 1'b1;
            end
            drpk_pkg::PH_DONE: ;
            default: ph = drpk_pkg::PH_ERROR;
        endcase

        if (ended)
        begin
            if (elem_no >= drpk_pkg::LAST_ELEMENT)
                ph = drpk_pkg::PH_DONE;
            else
            begin
                elem_no = elem_no + 3'd1;
                ph      = drpk_pkg::PH_INT_TAG;
            end
        end

        if (ph == drpk_pkg::PH_ERROR)
            key_status = drpk_pkg::ST_ERROR;
        else if (ph == drpk_pkg::PH_DONE)
            key_status = drpk_pkg::ST_DONE;
        if (it.last_byte && key_status == drpk_pkg::ST_PARSING)
            key_status = drpk_pkg::ST_ERROR;

        r.data_valid  = dv;
        r.element     = (dv || ended) ? el : 3'd0;
        r.data_byte   = dv ? b : 8'h00;
        r.element_end = ended;
        r.status      = key_status;

        if (it.last_byte)
            restart_parser();
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Key builders
    // -----------------------------------------------------------------------
    function automatic void add_length(input int unsigned n);
        int unsigned nb;
        int          k;
        if ($urandom_range(99) < bad_len_pct)
        begin
            key_bytes.push_back(LONG_FORM |
                8'($urandom_range(127, drpk_pkg::MAX_LENGTH_BYTES + 1)));
            return;
        end
        if (n < 128 && $urandom_range(3) != 0)
        begin
            key_bytes.push_back(8'(n));
            return;
        end
        nb = (n > 32'hFF_FFFF) ? 4 : (n > 32'hFFFF) ? 3 : (n > 32'hFF) ? 2 : (n != 0) ? 1 : 0;
        nb = $urandom_range(drpk_pkg::MAX_LENGTH_BYTES, nb);
        key_bytes.push_back(LONG_FORM | 8'(nb));
        for (k = nb - 1; k >= 0; k--)
            key_bytes.push_back(8'(n >> (8 * k)));
    endfunction

    // element whose content the parser skips over
    function automatic void add_skipped(input logic [7:0] tag, input int unsigned max_len);
        int unsigned n;
        n = $urandom_range(max_len);
        key_bytes.push_back(tag);
        add_length(n);
        repeat (n) key_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_integer();
        int unsigned n;
        int unsigned zeros;
        int          k;
        bit          all_zero;
        key_bytes.push_back(drpk_pkg::TAG_INTEGER);
        case ($urandom_range(99))
            0:             n = $urandom_range(200, 128);
            1, 2, 3, 4, 5: n = 0;
            6, 7, 8, 9:    n = $urandom_range(30, 12);
            default:       n = $urandom_range(8, 1);
        endcase
        add_length(n);
        all_zero = ($urandom_range(9) == 0);
        zeros    = $urandom_range(2);
        for (k = 0; k < n; k++)
            key_bytes.push_back((all_zero || k < zeros) ? 8'h00 : 8'($urandom));
    endfunction

    function automatic void build_key(input bit wrapped);
        key_bytes.delete();
        key_bytes.push_back(drpk_pkg::TAG_SEQUENCE);
        add_length($urandom_range(70000));
        add_skipped(drpk_pkg::TAG_INTEGER, 3);
        if (wrapped)
        begin
            add_skipped(drpk_pkg::TAG_SEQUENCE, 9);
            key_bytes.push_back(drpk_pkg::TAG_OCTETS);
            add_length($urandom_range(70000));
            key_bytes.push_back(drpk_pkg::TAG_SEQUENCE);
            add_length($urandom_range(70000));
            add_skipped(drpk_pkg::TAG_INTEGER, 3);
        end
        repeat (8) add_integer();
        // trailing bytes after qi
        repeat ($urandom_range(3)) key_bytes.push_back(8'($urandom));
    endfunction

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit is_last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_data  <= '{in_byte: b, last_byte: is_last};
        @(posedge clk);
        while (!key_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_key();
        int k;
        for (k = 0; k < key_bytes.size(); k++)
            send_byte(key_bytes[k], k == key_bytes.size() - 1);
        keys_sent++;
    endtask

    // drop valid and wait for every predicted word to come back
    task automatic wait_drain();
        key_valid <= 1'b0;
        @(posedge clk);
        while (parsed_due.size() != 0) @(posedge clk);
    endtask

    // receiver: random ready, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // -----------------------------------------------------------------------
    // Prediction and checking
    // -----------------------------------------------------------------------
    function automatic void flag_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, what);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && key_valid && key_ready)
            parsed_due.push_back(parse_key_byte(key_data));
    end

    always @(posedge clk)
    begin : check_results
        drpk_pkg::res_item_t want;
        string               bad;
        if (rst_n && res_valid && res_ready)
        begin
            if (parsed_due.size() == 0)
                flag_failure($sformatf("result word with nothing pending: %h", res_data));
            else
            begin
                want = parsed_due.pop_front();
                bad  = "";
                if (res_data.data_valid !== want.data_valid)   bad = {bad, " data_valid"};
                if (res_data.element !== want.element)         bad = {bad, " element"};
                if (res_data.data_byte !== want.data_byte)     bad = {bad, " data_byte"};
                if (res_data.element_end !== want.element_end) bad = {bad, " element_end"};
                if (res_data.status !== want.status)           bad = {bad, " status"};
                if (bad != "")
                    flag_failure($sformatf(
                        {"word %0d bad%s: exp dv=%0d el=%0d byte=%h end=%0d st=%0d,",
                         " got dv=%0d el=%0d byte=%h end=%0d st=%0d"},
                        words_checked, bad,
                        want.data_valid, want.element, want.data_byte,
                        want.element_end, want.status,
                        res_data.data_valid, res_data.element, res_data.data_byte,
                        res_data.element_end, res_data.status));
            end
            words_checked++;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // PKCS#1 key: zero outer length, skipped version, empty n, all-zero e,
    // long-form d with a leading zero, high-bit p, bytes after qi
    task automatic test_pkcs1_corners();
        key_bytes = '{drpk_pkg::TAG_SEQUENCE, LONG_FORM,
                      drpk_pkg::TAG_INTEGER, 8'h01, 8'h07,
                      drpk_pkg::TAG_INTEGER, 8'h00,
                      drpk_pkg::TAG_INTEGER, 8'h02, 8'h00, 8'h00,
                      drpk_pkg::TAG_INTEGER, LONG_FORM | 8'h01, 8'h02, 8'h00, 8'hFF,
                      drpk_pkg::TAG_INTEGER, 8'h01, 8'h80,
                      drpk_pkg::TAG_INTEGER, 8'h00, drpk_pkg::TAG_INTEGER, 8'h00,
                      drpk_pkg::TAG_INTEGER, 8'h00, drpk_pkg::TAG_INTEGER, 8'h00,
                      8'hA5};
        send_key();
        wait_drain();
    endtask

    // bad tag (sticky), over-long length count, end before qi
    task automatic test_error_paths();
        key_bytes = '{8'h31, drpk_pkg::TAG_SEQUENCE};
        send_key();
        key_bytes = '{drpk_pkg::TAG_SEQUENCE,
                      LONG_FORM | 8'(drpk_pkg::MAX_LENGTH_BYTES + 1)};
        send_key();
        key_bytes = '{drpk_pkg::TAG_SEQUENCE, 8'h00};
        send_key();
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering a whole key
    task automatic test_output_stall();
        rx_hold_req = STALL_CYCLES;
        build_key(1'b1);
        keys_wrapped++;
        send_key();
        wait_drain();
    endtask

    task automatic test_random_keys(input int n_bytes);
        int start;
        int kind;
        int cut;
        bit wrapped;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            kind    = $urandom_range(99);
            wrapped = $urandom_range(1);
            if (kind < 88)
            begin
                bad_len_pct = (kind >= 80) ? 8 : 0;
                build_key(wrapped);
                bad_len_pct = 0;
                keys_wrapped += wrapped;
                if (kind >= 70)
                    keys_damaged++;
                if (kind >= 70 && kind < 75)
                    key_bytes[$urandom_range(key_bytes.size() - 1)] = 8'($urandom);
                else if (kind >= 75 && kind < 80)
                begin
                    cut = $urandom_range(key_bytes.size() - 1, 1);
                    while (key_bytes.size() > cut) void'(key_bytes.pop_back());
                end
            end
            else
            begin
                key_bytes.delete();
                repeat ($urandom_range(12, 1)) key_bytes.push_back(8'($urandom));
                keys_noise++;
            end
            send_key();
        end
        wait_drain();
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    initial
    begin
        restart_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(31, 68);
        test_pkcs1_corners();
        test_error_paths();
        test_random_keys(430);

        set_idling(68, 31);
        test_random_keys(430);

        set_idling(0, 0);
        test_output_stall();
        test_random_keys(400);

        wait_drain();
        repeat (8) @(posedge clk);
        if (parsed_due.size() != 0)
            flag_failure($sformatf("%0d result words never arrived", parsed_due.size()));

        $display("Ran %0d keys (%0d PKCS#8, %0d damaged, %0d noise), %0d bytes in,",
                 keys_sent, keys_wrapped, keys_damaged, keys_noise, bytes_sent);
        $display("%0d result words checked, %0d failures", words_checked, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/drpk_pkg.sv
hw/rtl/drpk_step.sv
hw/rtl/der_rsa_private_key_parser.sv
tb/der_rsa_private_key_parser_tb.sv
